/* src/qbd_pkg.sv */
// qbd_pkg: shared types, constants and helpers for the qpsk burst demod block
// used by qbd_ctrl, qbd_datapath and the top level under src; no dependencies
`default_nettype none

package qbd_pkg;

  // default sizing of the burst
  localparam int SYM_CAP_DEF        = 4096;
  localparam int WEAK_RUN_LIMIT_DEF = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_TAN   = 2'd1;

  localparam logic [2:0] DROP_SHIFT_RST = 3'd3;
  localparam logic [9:0] CONF_TAN_RST   = 10'd435;

  // result kinds
  localparam logic KIND_DIBIT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // quadrant codes
  localparam logic [1:0] QUAD_PP = 2'd0;
  localparam logic [1:0] QUAD_NP = 2'd1;
  localparam logic [1:0] QUAD_NN = 2'd2;
  localparam logic [1:0] QUAD_PN = 2'd3;

  // input word
  typedef struct packed {
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic               last_of_burst;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        kind;
    logic [1:0]  symbol_bits;
    logic [15:0] level;
    logic [6:0]  confidence;
    logic [12:0] symbol_count;
    logic        last_result;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic sq_i;
    logic sq_q;
    logic root_start;
    logic decide;
    logic emit;
    logic div_sum_start;
    logic level_take;
    logic div_conf_start;
    logic summary;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic burst_ended;
    logic root_done;
    logic div_done;
    logic out_free;
    logic cand_left;
    logic summary_needed;
  } ctrl_stat_t;

  // differential phase step to dibit
  function automatic logic [1:0] dq_map(input logic [1:0] diff);
    logic [1:0] bits;
    case (diff)
      2'd0:    bits = 2'd0;
      2'd1:    bits = 2'd2;
      2'd2:    bits = 2'd3;
      2'd3:    bits = 2'd1;
      default: bits = 2'd0;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

/* src/qbd_isqrt.sv */
// qbd_isqrt: iterative integer square root of a 32-bit value, two bits per cycle
// depends on nothing; 16 steps, done pulses for one cycle as the last step is registered
`default_nettype none

module qbd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             done,
  output logic [15:0]      root
);

  logic [31:0] rem;
  logic [31:0] res;
  logic [31:0] bitv;
  logic        busy;
  logic [31:0] trial;
  logic        fits;

  // one digit of the root
  always_comb begin
    trial = res + bitv;
    fits  = (rem >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        res  <= 32'd0;
        bitv <= 32'h4000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[15:0];

endmodule

`default_nettype wire

/* src/qbd_div.sv */
// qbd_div: restoring unsigned divider, one quotient bit per cycle
// depends on nothing; DVD_W steps, done pulses after the last step
`default_nettype none

module qbd_div #(
  parameter int DVD_W = 29,
  parameter int DVS_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CW = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVS_W:0]   rem_sh;
  logic             fits;
  logic [DVS_W-1:0] rem_nx;

  // shift in one dividend bit and try the subtract
  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    fits   = (rem_sh >= {1'b0, divisor});
    rem_nx = fits ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        rem  <= '0;
        cnt  <= CW'(DVD_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem      <= rem_nx;
        dvd      <= dvd << 1;
        quotient <= {quotient[DVD_W-2:0], fits};
        cnt      <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/qbd_ctrl.sv */
// qbd_ctrl: sequencer for one symbol: square, root, decide, emit, summarize
// depends on qbd_pkg for the command and status structs
`default_nettype none

module qbd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire qbd_pkg::ctrl_stat_t stat,
  output qbd_pkg::ctrl_cmd_t       cmd
);

  import qbd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQI,
    S_SQQ,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DECIDE,
    S_EMIT,
    S_DSUM_GO,
    S_DSUM_WAIT,
    S_DCONF_GO,
    S_DCONF_WAIT,
    S_SUMMARY
  } state_t;

  state_t state;
  state_t state_next;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.burst_ended) state_next = S_SQI;
        end
      end
      S_SQI: begin
        cmd.sq_i   = 1'b1;
        state_next = S_SQQ;
      end
      S_SQQ: begin
        cmd.sq_q   = 1'b1;
        state_next = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_next     = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (stat.root_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.cand_left) begin
          cmd.emit = stat.out_free;
        end else if (stat.summary_needed) begin
          state_next = S_DSUM_GO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DSUM_GO: begin
        cmd.div_sum_start = 1'b1;
        state_next        = S_DSUM_WAIT;
      end
      S_DSUM_WAIT: begin
        if (stat.div_done) begin
          cmd.level_take = 1'b1;
          state_next     = S_DCONF_GO;
        end
      end
      S_DCONF_GO: begin
        cmd.div_conf_start = 1'b1;
        state_next         = S_DCONF_WAIT;
      end
      S_DCONF_WAIT: begin
        if (stat.div_done) state_next = S_SUMMARY;
      end
      S_SUMMARY: begin
        if (stat.out_free) begin
          cmd.summary = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

`default_nettype wire

/* src/qbd_datapath.sv */
// qbd_datapath: symbol arithmetic, burst state, held symbols and result register
// depends on qbd_pkg, qbd_isqrt and qbd_div
`default_nettype none

module qbd_datapath #(
  parameter int SYM_CAP        = qbd_pkg::SYM_CAP_DEF,
  parameter int WEAK_RUN_LIMIT = qbd_pkg::WEAK_RUN_LIMIT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [qbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [qbd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire qbd_pkg::in_word_t                  in_data,
  input  wire qbd_pkg::ctrl_cmd_t                 cmd,
  output qbd_pkg::ctrl_stat_t                     stat,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output qbd_pkg::out_word_t                      out_data
);

  import qbd_pkg::*;

  localparam int CNT_W = $clog2(SYM_CAP + 1);
  localparam int SUM_W = CNT_W + 16;
  localparam int NX_W  = CNT_W + 7;
  localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(SYM_CAP);
  localparam logic [1:0]       LIMIT_C = 2'(WEAK_RUN_LIMIT);

  // configuration
  logic [2:0]  drop_shift;
  logic [9:0]  conf_tan;

  // current symbol
  logic [15:0] ia;
  logic [15:0] qa;
  logic [1:0]  quad_cur;
  logic        near_cur;
  logic        last_l;
  logic [31:0] acc;

  // burst state
  logic [15:0]      peak;
  logic [1:0]       weak_run;
  logic [18:0]      held [2];
  logic [1:0]       prev;
  logic [SUM_W-1:0] mag_sum;
  logic [CNT_W-1:0] near_cnt;
  logic [CNT_W-1:0] kept;
  logic             burst_ended;

  // per-symbol plan
  logic       ended_l;
  logic [1:0] n_rel;
  logic [1:0] n_total;
  logic [1:0] cand;
  logic [15:0] level_q;

  // arithmetic units
  logic             root_done;
  logic [15:0]      mag;
  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;

  // combinational
  logic [15:0]      iu;
  logic [15:0]      qu;
  logic [15:0]      ia_in;
  logic [15:0]      qa_in;
  logic [1:0]       quad_in;
  logic [15:0]      mx;
  logic [15:0]      mn;
  logic [25:0]      tan_prod;
  logic [31:0]      sq_i;
  logic [31:0]      sq_q;
  logic [15:0]      peak_next;
  logic [22:0]      mag_sh;
  logic             is_weak;
  logic [1:0]       wr_new;
  logic             end_w;
  logic [18:0]      cur_packed;
  logic [18:0]      sel;
  logic [1:0]       diff;
  logic [CNT_W-1:0] kept_inc;
  logic [1:0]       cand_inc;
  logic             emit_last;
  logic [NX_W-1:0]  near_x100;
  logic             clear_now;
  logic             out_free;

  // square root and shared divider
  qbd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (acc),
    .done     (root_done),
    .root     (mag)
  );

  assign div_start = cmd.div_sum_start | cmd.div_conf_start;

  qbd_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (kept),
    .done     (div_done),
    .quotient (div_quo)
  );

  // symbol arithmetic and decision
  always_comb begin
    iu      = in_data.i_sample;
    qu      = in_data.q_sample;
    ia_in   = iu[15] ? (~iu + 16'd1) : iu;
    qa_in   = qu[15] ? (~qu + 16'd1) : qu;
    case ({iu[15], qu[15]})
      2'b00:   quad_in = QUAD_PP;
      2'b10:   quad_in = QUAD_NP;
      2'b11:   quad_in = QUAD_NN;
      2'b01:   quad_in = QUAD_PN;
      default: quad_in = QUAD_PP;
    endcase

    mx       = (ia > qa) ? ia : qa;
    mn       = (ia > qa) ? qa : ia;
    tan_prod = {10'd0, mx} * {16'd0, conf_tan};
    sq_i     = {16'd0, ia} * {16'd0, ia};
    sq_q     = {16'd0, qa} * {16'd0, qa};

    peak_next = (mag > peak) ? mag : peak;
    mag_sh    = {7'd0, mag} << drop_shift;
    is_weak   = (mag_sh < {7'd0, peak_next});
    wr_new    = weak_run + 2'd1;
    end_w     = is_weak && (wr_new >= LIMIT_C);
    cur_packed = {mag, near_cur, quad_cur};

    sel       = (cand < n_rel) ? held[cand[0]] : cur_packed;
    diff      = sel[1:0] - prev;
    kept_inc  = kept + CNT_W'(1);
    cand_inc  = cand + 2'd1;
    emit_last = (kept_inc != MAX_C) && !(cand_inc < n_total) && !last_l;

    near_x100    = {7'd0, near_cnt} * NX_W'(100);
    div_dividend = cmd.div_conf_start ? SUM_W'(near_x100) : mag_sum;

    clear_now = (cmd.load && burst_ended && in_data.last_of_burst)
              || (cmd.summary && last_l);
    out_free  = !out_valid || out_ready;
  end

  // status to the controller
  always_comb begin
    stat.burst_ended    = burst_ended;
    stat.root_done      = root_done;
    stat.div_done       = div_done;
    stat.out_free       = out_free;
    stat.cand_left      = (cand < n_total) && (kept < MAX_C);
    stat.summary_needed = ended_l || last_l || (kept >= MAX_C);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_shift <= DROP_SHIFT_RST;
      conf_tan   <= CONF_TAN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DROP_SHIFT: drop_shift <= cfg_data[2:0];
        REG_CONF_TAN:   conf_tan   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // symbol front end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ia       <= ia_in;
      qa       <= qa_in;
      quad_cur <= quad_in;
      last_l   <= in_data.last_of_burst;
    end
    if (cmd.sq_i) begin
      acc      <= sq_i;
      near_cur <= (mx != 16'd0) && ({mn, 10'd0} >= tan_prod);
    end
    if (cmd.sq_q) acc <= acc + sq_q;
    if (cmd.level_take) level_q <= div_quo[15:0];
  end

  // held symbols
  always_ff @(posedge clk) begin
    if (cmd.decide && is_weak && !end_w) held[1'(wr_new - 2'd1)] <= cur_packed;
  end

  // burst state and plan
  always_ff @(posedge clk) begin
    if (rst) begin
      peak        <= '0;
      weak_run    <= '0;
      prev        <= '0;
      mag_sum     <= '0;
      near_cnt    <= '0;
      kept        <= '0;
      burst_ended <= 1'b0;
      ended_l     <= 1'b0;
      n_rel       <= '0;
      n_total     <= '0;
      cand        <= '0;
    end else if (clear_now) begin
      peak        <= '0;
      weak_run    <= '0;
      prev        <= '0;
      mag_sum     <= '0;
      near_cnt    <= '0;
      kept        <= '0;
      burst_ended <= 1'b0;
    end else begin
      if (cmd.decide) begin
        peak     <= peak_next;
        weak_run <= (is_weak && !end_w && !last_l) ? wr_new : 2'd0;
        ended_l  <= end_w;
        cand     <= '0;
        if (is_weak) begin
          n_rel   <= (!end_w && last_l) ? wr_new : 2'd0;
          n_total <= (!end_w && last_l) ? wr_new : 2'd0;
        end else begin
          n_rel   <= weak_run;
          n_total <= weak_run + 2'd1;
        end
      end
      if (cmd.emit) begin
        prev     <= sel[1:0];
        mag_sum  <= mag_sum + SUM_W'(sel[18:3]);
        near_cnt <= near_cnt + CNT_W'(sel[2]);
        kept     <= kept_inc;
        cand     <= cand_inc;
      end
      if (cmd.summary) burst_ended <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid                 <= 1'b1;
      out_data.kind             <= KIND_DIBIT;
      out_data.symbol_bits      <= dq_map(diff);
      out_data.level            <= '0;
      out_data.confidence       <= '0;
      out_data.symbol_count     <= '0;
      out_data.last_result      <= emit_last;
    end else if (cmd.summary) begin
      out_valid                 <= 1'b1;
      out_data.kind             <= KIND_SUMMARY;
      out_data.symbol_bits      <= '0;
      out_data.level            <= (kept == '0) ? 16'd0 : level_q;
      out_data.confidence       <= (kept == '0) ? 7'd0 : div_quo[6:0];
      out_data.symbol_count     <= 13'(kept);
      out_data.last_result      <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept <= MAX_C)
    else $error("kept count above limit");

  a_weak_bound: assert property (@(posedge clk) disable iff (rst)
    weak_run < LIMIT_C)
    else $error("weak run reached its limit without ending");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.summary) |-> out_free)
    else $error("result written over an untaken word");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_SUMMARY) |-> out_data.last_result)
    else $error("summary not marked last");

  a_ended_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && burst_ended) |=> !cmd.decide && !cmd.emit)
    else $error("symbol processed after end of burst");
`endif

endmodule

`default_nettype wire

/* src/qpsk_burst_demod_dqpsk.sv */
// qpsk_burst_demod_dqpsk: top level of the hard-decision qpsk / dqpsk burst decoder
// depends on qbd_pkg, qbd_ctrl and qbd_datapath
//
// in channel: one i/q symbol word per handshake (in_valid / in_ready).
// out channel: dibit words and one summary word per burst (out_valid / out_ready),
// last_result marks the final word caused by an input word.
// cfg channel: register writes (cfg_index 0 drop_shift, 1 confidence_tan), always ready.
// one word at a time: after accept the sequencer squares i and q, runs the 16-step
// square root and decides, then emits each dibit when the output slot is free;
// in_ready returns once the word's dibits and any summary word are out.
// a summary adds two serial divisions of clog2(SYM_CAP+1)+16 steps each.
// a word after end of burst, up to and including the next last_of_burst, is
// taken with no result while the sequencer stays idle.
// a registered output word lets the block finish an item while the last word
// waits; if the receiver stalls, the sequencer waits on the output slot.
// reset (rst, synchronous) clears the burst state and loads register defaults.
`default_nettype none

module qpsk_burst_demod_dqpsk #(
  parameter int SYM_CAP        = qbd_pkg::SYM_CAP_DEF,
  parameter int WEAK_RUN_LIMIT = qbd_pkg::WEAK_RUN_LIMIT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire qbd_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output qbd_pkg::out_word_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [qbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import qbd_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  qbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qbd_datapath #(
    .SYM_CAP        (SYM_CAP),
    .WEAK_RUN_LIMIT (WEAK_RUN_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/tb_qpsk_burst_demod_dqpsk.sv */
// tb_qpsk_burst_demod_dqpsk: self-checking bench for the qpsk / dqpsk burst decoder
// needs qbd_pkg and qpsk_burst_demod_dqpsk; a class tracks burst state and expected words
`timescale 1ns / 1ps

module tb_qpsk_burst_demod_dqpsk;
  import qbd_pkg::*;

  localparam int SYM_LIMIT     = SYM_CAP_DEF;
  localparam int RUN_LIMIT     = WEAK_RUN_LIMIT_DEF;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;

  // one decided symbol as kept in the hold slots
  typedef struct packed {
    logic [15:0] mag;
    logic        near;
    logic [1:0]  quad;
  } sym_t;

  // burst state tracker and expected word store
  class burst_tracker;
    logic [2:0]      drop_shift;
    logic [9:0]      conf_tan;
    int unsigned     peak_mag;
    int unsigned     faint_run;
    logic [1:0]      prev_quad;
    longint unsigned mag_sum;
    int unsigned     near_count;
    int unsigned     kept_count;
    bit              burst_ended;
    sym_t            held[2];
    logic [1:0]      step_dibit[4];
    out_word_t       batch[4];
    int              nbatch;
    out_word_t       expected_words[$];
    int              errors;

    function new();
      step_dibit = '{2'd0, 2'd2, 2'd3, 2'd1};
      drop_shift = DROP_SHIFT_RST;
      conf_tan   = CONF_TAN_RST;
      errors     = 0;
      clear_burst();
    endfunction

    function void clear_burst();
      peak_mag    = 0;
      faint_run   = 0;
      prev_quad   = QUAD_PP;
      mag_sum     = 0;
      near_count  = 0;
      kept_count  = 0;
      burst_ended = 1'b0;
      held[0]     = '0;
      held[1]     = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_DROP_SHIFT) drop_shift = val[2:0];
      else if (idx == REG_CONF_TAN) conf_tan = val[9:0];
    endfunction

    // bitwise square root, floor
    function int unsigned int_sqrt(int unsigned v);
      int unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // keep one symbol and queue its dibit word
    function void keep_symbol(sym_t s);
      out_word_t r;
      if (kept_count >= SYM_LIMIT) return;
      r = '0;
      r.kind        = KIND_DIBIT;
      r.symbol_bits = step_dibit[s.quad - prev_quad];
      prev_quad     = s.quad;
      mag_sum      += s.mag;
      if (s.near) near_count++;
      kept_count++;
      batch[nbatch] = r;
      nbatch++;
    endfunction

    function void release_held();
      for (int j = 0; j < faint_run && j < 2; j++) keep_symbol(held[j]);
      faint_run = 0;
    endfunction

    // work out the words caused by one accepted symbol
    function void note_symbol(in_word_t w);
      int          iv, qv;
      int unsigned ia, qa, mag, mx, mn;
      bit          is_faint, ends;
      sym_t        s;
      out_word_t   r;
      nbatch = 0;
      ends   = 1'b0;
      if (burst_ended) begin
        if (w.last_of_burst) clear_burst();
        return;
      end
      iv = w.i_sample;
      qv = w.q_sample;
      ia = (iv < 0) ? -iv : iv;
      qa = (qv < 0) ? -qv : qv;
      mag = int_sqrt(ia * ia + qa * qa);
      if (mag > peak_mag) peak_mag = mag;
      if (iv >= 0 && qv >= 0) s.quad = QUAD_PP;
      else if (iv < 0 && qv >= 0) s.quad = QUAD_NP;
      else if (iv < 0) s.quad = QUAD_NN;
      else s.quad = QUAD_PN;
      mx = (ia > qa) ? ia : qa;
      mn = (ia > qa) ? qa : ia;
      s.near = (mx != 0) && (mn * 1024 >= mx * conf_tan);
      s.mag  = mag[15:0];
      is_faint = (mag << drop_shift) < peak_mag;

      // faint symbols wait in the hold slots, a long run ends the burst
      if (is_faint) begin
        faint_run++;
        if (faint_run >= RUN_LIMIT) begin
          faint_run = 0;
          ends = 1'b1;
        end else begin
          held[(faint_run - 1) % 2] = s;
        end
      end else begin
        release_held();
        keep_symbol(s);
      end
      if (!ends && w.last_of_burst) release_held();
      if (!ends && kept_count >= SYM_LIMIT) begin
        faint_run = 0;
        ends = 1'b1;
      end

      // end of burst summary
      if (ends || w.last_of_burst) begin
        r = '0;
        r.kind = KIND_SUMMARY;
        if (kept_count > 0) begin
          r.level      = 16'(mag_sum / kept_count);
          r.confidence = 7'((near_count * 100) / kept_count);
        end
        r.symbol_count = 13'(kept_count);
        batch[nbatch] = r;
        nbatch++;
        if (w.last_of_burst) clear_burst();
        else burst_ended = 1'b1;
      end
      if (nbatch > 0) batch[nbatch-1].last_result = 1'b1;
      for (int k = 0; k < nbatch; k++) expected_words.push_back(batch[k]);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d bits=%0d level=%0d conf=%0d count=%0d last=%0d",
                 $time, got.kind, got.symbol_bits, got.level, got.confidence,
                 got.symbol_count, got.last_result);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.kind !== exp_w.kind || got.symbol_bits !== exp_w.symbol_bits ||
          got.level !== exp_w.level || got.confidence !== exp_w.confidence ||
          got.symbol_count !== exp_w.symbol_count || got.last_result !== exp_w.last_result)
      begin
        $display("%0t: mismatch expected kind=%0d bits=%0d level=%0d conf=%0d count=%0d last=%0d",
                 $time, exp_w.kind, exp_w.symbol_bits, exp_w.level, exp_w.confidence,
                 exp_w.symbol_count, exp_w.last_result);
        $display("%0t:          actual   kind=%0d bits=%0d level=%0d conf=%0d count=%0d last=%0d",
                 $time, got.kind, got.symbol_bits, got.level, got.confidence,
                 got.symbol_count, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  burst_tracker sb;
  int           tx_idle_pct;
  int           rx_idle_pct;
  bit           hold_req;
  int           cycle_count;

  qpsk_burst_demod_dqpsk DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // handshake monitor on all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_symbol(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_symbol(input in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, let every expected word arrive and the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_word_t mk(int iv, int qv, bit last);
    in_word_t w;
    w.i_sample      = 16'(iv);
    w.q_sample      = 16'(qv);
    w.last_of_burst = last;
    return w;
  endfunction

  // word from two magnitudes with random signs
  function automatic in_word_t pair_word(int imag, int qmag);
    return mk($urandom_range(1) ? -imag : imag, $urandom_range(1) ? -qmag : qmag, 1'b0);
  endfunction

  // strong symbol, sometimes right at the confidence tangent boundary
  function automatic in_word_t strong_symbol(int amp);
    int m, mx, mn;
    if ($urandom_range(99) < 15) begin
      m  = $urandom_range(4, 31);
      mx = 1024 * m;
      mn = m * sb.conf_tan - $urandom_range(0, 1);
      if (mn < 0) mn = 0;
      return $urandom_range(1) ? pair_word(mx, mn) : pair_word(mn, mx);
    end
    return pair_word($urandom_range(amp / 2, amp), $urandom_range(amp / 2, amp));
  endfunction

  function automatic in_word_t faint_symbol(int amp);
    int hi;
    hi = amp >> (sb.drop_shift + 3);
    return pair_word($urandom_range(0, hi), $urandom_range(0, hi));
  endfunction

  // one random burst: mostly well formed, sometimes raw noise
  task automatic gen_burst(inout int counted);
    int       len, amp, k, run, j, fill;
    bit       ended;
    in_word_t w;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, 6);
      for (k = 0; k < len; k++) begin
        w.i_sample      = 16'($urandom);
        w.q_sample      = 16'($urandom);
        w.last_of_burst = (k == len - 1) || ($urandom_range(7) == 0);
        send_symbol(w);
        counted++;
      end
      return;
    end
    len   = $urandom_range(2, 14);
    amp   = $urandom_range(1000, 32767);
    k     = 0;
    ended = 1'b0;
    while (k < len && !ended) begin
      run = (k > 0 && $urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
      if (run > 0) begin
        for (j = 0; j < run && k < len; j++) begin
          w = faint_symbol(amp);
          w.last_of_burst = (k == len - 1);
          send_symbol(w);
          counted++;
          k++;
        end
        ended = (j == RUN_LIMIT) && !w.last_of_burst;
      end else begin
        w = strong_symbol(amp);
        w.last_of_burst = (k == len - 1);
        send_symbol(w);
        counted++;
        k++;
      end
    end
    // after a weak-run end: ignored symbols, then the closing mark
    if (ended) begin
      fill = $urandom_range(0, 2);
      for (j = 0; j < fill; j++) begin
        send_symbol(strong_symbol(amp));
        counted++;
      end
      w = strong_symbol(amp);
      w.last_of_burst = 1'b1;
      send_symbol(w);
      counted++;
    end
  endtask

  initial begin
    int counted;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_DROP_SHIFT;
    cfg_data    = '0;
    hold_req    = 1'b0;
    cycle_count = 0;
    tx_idle_pct = 7;
    rx_idle_pct = 55;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, quadrant edges, zero vector, hold and release
    send_symbol(mk(32767, 32767, 1'b0));
    send_symbol(mk(-32768, 100, 1'b0));
    send_symbol(mk(-32768, -32768, 1'b0));
    send_symbol(mk(0, -30000, 1'b0));
    send_symbol(mk(0, 0, 1'b0));
    send_symbol(mk(20000, 0, 1'b0));
    send_symbol(mk(100, 100, 1'b0));
    send_symbol(mk(-100, 50, 1'b0));
    send_symbol(mk(30000, -30000, 1'b0));
    // held symbols released by the last mark
    send_symbol(mk(10, 10, 1'b0));
    send_symbol(mk(10, -10, 1'b1));
    // weak-run end, ignored symbol, last mark after the end
    send_symbol(mk(-20000, 20000, 1'b0));
    send_symbol(mk(5, 5, 1'b0));
    send_symbol(mk(5, 5, 1'b0));
    send_symbol(mk(5, 5, 1'b0));
    send_symbol(mk(30000, 30000, 1'b0));
    send_symbol(mk(1, 1, 1'b1));
    // single-symbol burst
    send_symbol(mk(32767, -32768, 1'b1));
    // weak-run end and last mark on the same symbol
    send_symbol(mk(15000, 15000, 1'b0));
    send_symbol(mk(3, 3, 1'b0));
    send_symbol(mk(3, 3, 1'b0));
    send_symbol(mk(3, 3, 1'b1));
    // zero vector alone
    send_symbol(mk(0, 0, 1'b1));

    // high extremes
    settle();
    write_reg(REG_DROP_SHIFT, 10'd7);
    write_reg(REG_CONF_TAN, 10'd1023);
    counted = 0;
    while (counted < 40) gen_burst(counted);

    // low extremes, sender now idles more than receiver
    settle();
    tx_idle_pct = 55;
    rx_idle_pct = 7;
    write_reg(REG_DROP_SHIFT, 10'd0);
    write_reg(REG_CONF_TAN, 10'd0);
    while (counted < 80) gen_burst(counted);

    // random mid setting
    settle();
    write_reg(REG_DROP_SHIFT, 10'($urandom_range(1, 6)));
    write_reg(REG_CONF_TAN, 10'($urandom_range(1, 1022)));
    while (counted < 120) gen_burst(counted);

    // no idling, long receiver hold-off to back the block up
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_DROP_SHIFT, 10'(DROP_SHIFT_RST));
    write_reg(REG_CONF_TAN, 10'(CONF_TAN_RST));
    hold_req = 1'b1;
    while (counted < 160) gen_burst(counted);

    settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* qpsk_burst_demod_dqpsk.f */
src/qbd_pkg.sv
src/qbd_isqrt.sv
src/qbd_div.sv
src/qbd_ctrl.sv
src/qbd_datapath.sv
src/qpsk_burst_demod_dqpsk.sv
tb/tb_qpsk_burst_demod_dqpsk.sv
